[rtl/assert_macros.svh]
// assertion macros used by the mapper controller
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define MBR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must hold on every rising clock edge outside reset
`define MBR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   `MBR_ASSERT(label, clk, rst, (1'b1) |-> (cond), msg)

`endif

[rtl/mbr_pkg.sv]
// codes, constants and control structs of the boot record block mapper
// no dependencies
package mbr_pkg;

   localparam logic [1:0] KIND_RECORD     = 2'd0;
   localparam logic [1:0] KIND_HALF_BLOCK = 2'd1;
   localparam logic [1:0] KIND_FULL_BLOCK = 2'd2;

   localparam logic [1:0] STATUS_TABLE_OK  = 2'd0;
   localparam logic [1:0] STATUS_FALLBACK  = 2'd1;
   localparam logic [1:0] STATUS_TRANSLATE = 2'd2;

   localparam logic [1:0] REG_CYLINDERS = 2'd0;
   localparam logic [1:0] REG_SECTORS   = 2'd1;
   localparam logic [1:0] REG_HEADS     = 2'd2;

   localparam int unsigned ENTRIES = 4;

   localparam logic [8:0] TABLE_BASE   = 9'h1be;
   localparam logic [8:0] TABLE_END    = 9'h1fe;
   localparam logic [8:0] SIG_LOW_POS  = 9'd510;
   localparam logic [8:0] SIG_HIGH_POS = 9'd511;
   localparam logic [7:0] SIG_LOW      = 8'h55;
   localparam logic [7:0] SIG_HIGH     = 8'haa;

   typedef enum logic {
      ST_RUN,
      ST_FALLBACK
   } ctrl_state_type;

   typedef struct packed {
      logic take;
      logic finish_fallback;
   } mbr_cmd_type;

   typedef struct packed {
      logic produces;
      logic bad_commit;
   } mbr_stat_type;

endpackage

[rtl/mbr_datapath.sv]
// datapath: record staging, partition table, translation adder, result register
// depends on mbr_pkg
module mbr_datapath
   import mbr_pkg::*;
#(
   parameter int ADDRESS_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   kind,
   input  logic [7:0]   record_byte,
   input  logic [2:0]   partition,
   input  logic [31:0]  block_number,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data,
   input  mbr_cmd_type  cmd,
   output mbr_stat_type stat,
   output logic [1:0]   status,
   output logic [31:0]  sector_address,
   output logic         upper_half,
   output logic [7:0]   partition_type,
   output logic         range_flag
);

   localparam int SUM_W = ADDRESS_WIDTH + 1;

   logic [15:0] cylinders_ff, cylinders_in;
   logic [7:0]  sectors_ff, sectors_in;
   logic [7:0]  heads_ff, heads_in;

   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  sig_low_ff, sig_low_in;
   logic [7:0]  staged_type_ff [ENTRIES], staged_type_in [ENTRIES];
   logic [31:0] staged_start_ff [ENTRIES], staged_start_in [ENTRIES];
   logic [31:0] staged_size_ff [ENTRIES], staged_size_in [ENTRIES];
   logic [7:0]  table_type_ff [ENTRIES], table_type_in [ENTRIES];
   logic [31:0] table_start_ff [ENTRIES], table_start_in [ENTRIES];
   logic [31:0] table_size_ff [ENTRIES], table_size_in [ENTRIES];
   logic [23:0] mul_ff, mul_in;

   logic [1:0]  status_ff, status_in;
   logic [31:0] addr_ff, addr_in;
   logic        half_ff, half_in;
   logic [7:0]  ptype_ff, ptype_in;
   logic        flag_ff, flag_in;

   logic [8:0]  rel;
   logic [1:0]  ent;
   logic [3:0]  off;
   logic        in_table;
   logic        is_record;
   logic        commit;
   logic        sig_ok;
   logic        translate;
   logic [1:0]  idx;
   logic [31:0] offset;
   logic [SUM_W-1:0] sum;
   logic [31:0] fallback_size;

   assign rel       = pos_ff - TABLE_BASE;
   assign ent       = rel[5:4];
   assign off       = rel[3:0];
   assign in_table  = (pos_ff >= TABLE_BASE) && (pos_ff < TABLE_END);
   assign is_record = (kind == KIND_RECORD);
   assign commit    = is_record && (pos_ff == SIG_HIGH_POS);
   assign sig_ok    = (sig_low_ff == SIG_LOW) && (record_byte == SIG_HIGH);
   assign translate = (kind == KIND_HALF_BLOCK) || (kind == KIND_FULL_BLOCK);
   assign idx       = partition[1:0];
   assign offset    = (kind == KIND_HALF_BLOCK) ? {1'b0, block_number[31:1]} : block_number;
   assign sum       = SUM_W'(offset) + SUM_W'(table_start_ff[idx]);
   assign fallback_size = {8'd0, mul_ff} * {24'd0, heads_ff};

   assign stat.produces   = commit || translate;
   assign stat.bad_commit = commit && !sig_ok;

   // configuration registers
   always_comb begin
      cylinders_in = cylinders_ff;
      sectors_in   = sectors_ff;
      heads_in     = heads_ff;
      if (csr_write) begin
         case (csr_index)
            REG_CYLINDERS: cylinders_in = csr_data;
            REG_SECTORS:   sectors_in   = csr_data[7:0];
            REG_HEADS:     heads_in     = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      sig_low_in = sig_low_ff;
      mul_in     = mul_ff;
      status_in  = status_ff;
      addr_in    = addr_ff;
      half_in    = half_ff;
      ptype_in   = ptype_ff;
      flag_in    = flag_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         staged_type_in[i]  = staged_type_ff[i];
         staged_start_in[i] = staged_start_ff[i];
         staged_size_in[i]  = staged_size_ff[i];
         table_type_in[i]   = table_type_ff[i];
         table_start_in[i]  = table_start_ff[i];
         table_size_in[i]   = table_size_ff[i];
      end

      if (cmd.take) begin
         case (kind)
            KIND_RECORD: begin
               pos_in = pos_ff + 9'd1;
               if (in_table) begin
                  if (off == 4'd4) begin
                     staged_type_in[ent] = record_byte;
                  end else if (off[3:2] == 2'b10) begin
                     staged_start_in[ent][8*off[1:0] +: 8] = record_byte;
                  end else if (off[3:2] == 2'b11) begin
                     staged_size_in[ent][8*off[1:0] +: 8] = record_byte;
                  end
               end else if (pos_ff == SIG_LOW_POS) begin
                  sig_low_in = record_byte;
               end else if (commit) begin
                  addr_in  = '0;
                  half_in  = 1'b0;
                  ptype_in = '0;
                  flag_in  = 1'b0;
                  if (sig_ok) begin
                     status_in = STATUS_TABLE_OK;
                     for (int i = 0; i < ENTRIES; i++) begin
                        table_type_in[i] = staged_type_ff[i];
                        table_start_in[i] = (staged_type_ff[i] != 8'd0) ? staged_start_ff[i] : '0;
                        table_size_in[i]  = (staged_type_ff[i] != 8'd0) ? staged_size_ff[i] : '0;
                     end
                  end else begin
                     status_in = STATUS_FALLBACK;
                     for (int i = 0; i < ENTRIES; i++) begin
                        table_type_in[i]  = '0;
                        table_start_in[i] = '0;
                        table_size_in[i]  = '0;
                     end
                     table_type_in[0] = 8'd1;
                     mul_in = {8'd0, cylinders_ff} * {16'd0, sectors_ff};
                  end
               end
            end
            KIND_HALF_BLOCK, KIND_FULL_BLOCK: begin
               status_in = STATUS_TRANSLATE;
               if (partition[2]) begin
                  addr_in  = '0;
                  half_in  = 1'b0;
                  ptype_in = '0;
                  flag_in  = 1'b1;
               end else begin
                  addr_in  = sum[31:0];
                  half_in  = (kind == KIND_HALF_BLOCK) && block_number[0];
                  ptype_in = table_type_ff[idx];
                  flag_in  = sum[ADDRESS_WIDTH];
               end
            end
            default: ;
         endcase
      end

      // second step of the fallback whole-disk size
      if (cmd.finish_fallback) begin
         table_size_in[0] = fallback_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cylinders_ff <= '0;
         sectors_ff   <= '0;
         heads_ff     <= '0;
         pos_ff       <= '0;
         sig_low_ff   <= '0;
         mul_ff       <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            staged_type_ff[i]  <= '0;
            staged_start_ff[i] <= '0;
            staged_size_ff[i]  <= '0;
            table_type_ff[i]   <= '0;
            table_start_ff[i]  <= '0;
            table_size_ff[i]   <= '0;
         end
      end else begin
         cylinders_ff <= cylinders_in;
         sectors_ff   <= sectors_in;
         heads_ff     <= heads_in;
         pos_ff       <= pos_in;
         sig_low_ff   <= sig_low_in;
         mul_ff       <= mul_in;
         for (int i = 0; i < ENTRIES; i++) begin
            staged_type_ff[i]  <= staged_type_in[i];
            staged_start_ff[i] <= staged_start_in[i];
            staged_size_ff[i]  <= staged_size_in[i];
            table_type_ff[i]   <= table_type_in[i];
            table_start_ff[i]  <= table_start_in[i];
            table_size_ff[i]   <= table_size_in[i];
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      addr_ff   <= addr_in;
      half_ff   <= half_in;
      ptype_ff  <= ptype_in;
      flag_ff   <= flag_in;
   end

   assign status         = status_ff;
   assign sector_address = addr_ff;
   assign upper_half     = half_ff;
   assign partition_type = ptype_ff;
   assign range_flag     = flag_ff;

endmodule

[rtl/mbr_ctrl.sv]
// controller: input handshake, result register valid, fallback sequencing
// depends on mbr_pkg and assert_macros.svh
`include "assert_macros.svh"

module mbr_ctrl
   import mbr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  mbr_stat_type stat,
   output mbr_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN:      if (accept && stat.bad_commit) state_in = ST_FALLBACK;
         ST_FALLBACK: state_in = ST_RUN;
         default:     state_in = ST_RUN;
      endcase
   end

   always_comb begin
      req_tready          = 1'b0;
      cmd.take            = 1'b0;
      cmd.finish_fallback = 1'b0;
      case (state_ff)
         ST_RUN: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            cmd.take   = req_tvalid && (!rsp_valid_ff || rsp_tready);
         end
         ST_FALLBACK: cmd.finish_fallback = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && stat.produces) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `MBR_ASSERT(a_fallback_follows, clock, reset, accept && stat.bad_commit |=> state_ff == ST_FALLBACK, "bad signature commit did not start fallback")
   `MBR_ASSERT(a_no_take_in_fallback, clock, reset, state_ff == ST_FALLBACK |-> !req_tready && !cmd.take, "item taken during fallback")
   `MBR_ASSERT(a_result_follows, clock, reset, accept && stat.produces |=> rsp_valid_ff, "accepted item gave no result")
   `MBR_ASSERT_ALWAYS(a_take_is_accept, clock, reset, cmd.take == accept, "datapath take differs from handshake")

endmodule

[rtl/mbr_partition_block_mapper.sv]
// Takes a boot record one byte per beat and commits its four-entry partition table at
// byte 511, then maps partition-relative 256- or 512-byte blocks to absolute sectors.
// One item per cycle unless a result waits untaken or a fallback runs: a commit with a
// bad signature stalls input while the fallback size goes through two registered multiply
// steps. Results sit in one output register; while one waits, the next item is taken only
// in the cycle that result is taken. csr port is always ready; the user must write it only
// while the block is idle; nothing enforces it. Depends on mbr_pkg, mbr_ctrl, mbr_datapath.
module mbr_partition_block_mapper
   import mbr_pkg::*;
#(
   parameter int ADDRESS_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // record_byte, partition, block_number, zero pad
   input  logic [1:0]  req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // sector_address, upper_half, partition_type, range_flag, zero pad
   output logic [1:0]  rsp_tuser,  // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   mbr_cmd_type  cmd;
   mbr_stat_type stat;
   logic [31:0]  sector_address;
   logic         upper_half;
   logic [7:0]   partition_type;
   logic         range_flag;

   assign csr_ready = 1'b1;

   mbr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mbr_datapath #(
      .ADDRESS_WIDTH (ADDRESS_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .kind           (req_tuser),
      .record_byte    (req_tdata[7:0]),
      .partition      (req_tdata[10:8]),
      .block_number   (req_tdata[42:11]),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .stat           (stat),
      .status         (rsp_tuser),
      .sector_address (sector_address),
      .upper_half     (upper_half),
      .partition_type (partition_type),
      .range_flag     (range_flag)
   );

   assign rsp_tdata = {6'd0, range_flag, partition_type, upper_half, sector_address};

endmodule
